### hdl/brnm_pkg.sv
// brnm_pkg: shared types and constants for the byte range normalize/merge block
// request, result, stored range, cell and merge control and state types; no dependencies
`timescale 1ns / 1ps

package brnm_pkg;

   localparam int OFS_BITS = 48;

   typedef logic [OFS_BITS-1:0] offset_type;

   typedef struct packed {
      offset_type range_start;
      logic       start_absent;
      offset_type range_end;
      logic       end_absent;
      logic       last_range;
   } req_type;

   typedef struct packed {
      offset_type merged_start;
      offset_type merged_end;
      logic       last_merged;
      logic       overflow;
   } rsp_type;

   // one normalized range as kept in the sorted chain
   typedef struct packed {
      offset_type ent_start;
      offset_type ent_stop;
   } entry_type;

   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctl_type;

   typedef struct packed {
      logic pop;
      logic flush;
   } merge_ctl_type;

   typedef enum logic [1:0] {
      ST_FILL  = 2'b01,
      ST_MERGE = 2'b10
   } state_type;

endpackage

### hdl/brnm_norm.sv
// brnm_norm: clamps one requested range against the stream size
// combinational; depends on brnm_pkg
`timescale 1ns / 1ps

module brnm_norm (
   input  brnm_pkg::req_type    req,
   input  brnm_pkg::offset_type size,
   output brnm_pkg::entry_type  ent
);

   brnm_pkg::offset_type last_byte;
   brnm_pkg::offset_type len;

   assign last_byte = size - brnm_pkg::OFS_BITS'(1);

   always_comb begin
      len = size;
      ent.ent_start = req.range_start;
      ent.ent_stop = req.range_end;
      if (req.start_absent) begin
         // suffix form: the last min(end, size) bytes
         if (!req.end_absent && (req.range_end < size)) begin
            len = req.range_end;
         end
         ent.ent_start = size - len;
         ent.ent_stop = last_byte;
      end else if (req.end_absent || (req.range_end >= size)) begin
         ent.ent_stop = last_byte;
      end
   end

endmodule

### hdl/brnm_cell.sv
// brnm_cell: one slot of the sorted insertion chain
// shifts right to make room on insert, shifts left on drain; depends on brnm_pkg
`timescale 1ns / 1ps

module brnm_cell (
   input  logic                   clock,
   input  brnm_pkg::cell_ctl_type ctl,
   input  logic                   occupied,
   input  brnm_pkg::entry_type    new_ent,
   input  brnm_pkg::entry_type    left_ent,
   input  logic                   left_take,
   input  brnm_pkg::entry_type    right_ent,
   output brnm_pkg::entry_type    ent,
   output logic                   take
);

   brnm_pkg::entry_type ent_ff;
   brnm_pkg::entry_type ent_in;

   // strictly greater keeps equal starts ahead of the new range
   assign take = !occupied || (ent_ff.ent_start > new_ent.ent_start);
   assign ent = ent_ff;

   always_comb begin
      ent_in = ent_ff;
      if (ctl.insert) begin
         if (take) begin
            ent_in = left_take ? left_ent : new_ent;
         end
      end else if (ctl.shift) begin
         ent_in = right_ent;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

endmodule

### hdl/brnm_merge.sv
// brnm_merge: folds ranges drained in start order and registers the results
// depends on brnm_pkg
`timescale 1ns / 1ps

module brnm_merge (
   input  logic                    clock,
   input  logic                    reset,
   input  brnm_pkg::merge_ctl_type ctl,
   input  brnm_pkg::entry_type     ent,
   input  logic                    overflow,
   output logic                    rsp_strobe,
   output brnm_pkg::rsp_type       rsp_data
);

   localparam int W1 = brnm_pkg::OFS_BITS + 1;

   brnm_pkg::entry_type cur_ff, cur_in;
   logic                have_ff, have_in;
   logic                strobe_ff, strobe_in;
   brnm_pkg::rsp_type   data_ff, data_in;
   logic                touch;

   // end + 1 one bit wider so an all-ones end does not wrap
   assign touch = ({1'b0, ent.ent_start} <= ({1'b0, cur_ff.ent_stop} + W1'(1)));

   always_comb begin
      cur_in = cur_ff;
      have_in = have_ff;
      strobe_in = 1'b0;
      data_in = data_ff;
      if (ctl.pop) begin
         if (have_ff && touch) begin
            if (ent.ent_stop > cur_ff.ent_stop) begin
               cur_in.ent_stop = ent.ent_stop;
            end
         end else begin
            if (have_ff) begin
               strobe_in = 1'b1;
               data_in.merged_start = cur_ff.ent_start;
               data_in.merged_end = cur_ff.ent_stop;
               data_in.last_merged = 1'b0;
               data_in.overflow = overflow;
            end
            cur_in = ent;
            have_in = 1'b1;
         end
      end else if (ctl.flush) begin
         strobe_in = have_ff;
         data_in.merged_start = cur_ff.ent_start;
         data_in.merged_end = cur_ff.ent_stop;
         data_in.last_merged = 1'b1;
         data_in.overflow = overflow;
         have_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         have_ff <= have_in;
         strobe_ff <= strobe_in;
      end
      cur_ff <= cur_in;
      data_ff <= data_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data = data_ff;

endmodule

### hdl/byte_range_normalize_merge.sv
// byte_range_normalize_merge: top level, normalizer, sorted cell chain and merger
// depends on brnm_pkg, brnm_norm, brnm_cell, brnm_merge
`timescale 1ns / 1ps

// A range is taken whenever start is high and busy is low, one per clock: it
// is clamped against stream_size in the accept cycle and slotted into a chain
// of MAX_RANGES cells in the next. Busy is high from the insert cycle of the
// range marked last_range until the chain has drained and the merger has
// flushed: the chain hands one stored range per clock to the merger, and the
// merged ranges come out on rsp_strobe / rsp_data, one per clock at most,
// each for a single cycle. The receiver cannot stall, so it must take every
// strobed result. Ranges beyond MAX_RANGES are dropped and reported through
// the overflow bit of every result of that request. The csr channel is
// always ready; write stream_size only while busy is low and no range is in
// flight.

module byte_range_normalize_merge #(
   parameter int MAX_RANGES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  brnm_pkg::req_type   req_data,
   output logic                rsp_strobe,
   output brnm_pkg::rsp_type   rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  brnm_pkg::offset_type csr_data
);

   localparam int CNT_W = $clog2(MAX_RANGES + 1);

   brnm_pkg::offset_type    size_ff;
   brnm_pkg::state_type     state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    dropped_ff, dropped_in;
   logic                    pend_valid_ff;
   logic                    pend_last_ff;
   brnm_pkg::entry_type     pend_ff;
   brnm_pkg::entry_type     norm_ent;
   logic                    accept;
   logic                    full;
   brnm_pkg::cell_ctl_type  cell_ctl;
   brnm_pkg::merge_ctl_type merge_ctl;
   brnm_pkg::entry_type     ent_w [MAX_RANGES];
   logic                    take_w [MAX_RANGES];

   assign csr_ready = 1'b1;
   assign busy = (state_ff == brnm_pkg::ST_MERGE) || (pend_valid_ff && pend_last_ff);
   assign accept = start && !busy;
   assign full = (count_ff == CNT_W'(MAX_RANGES));

   brnm_norm u_norm (
      .req  (req_data),
      .size (size_ff),
      .ent  (norm_ent)
   );

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      dropped_in = dropped_ff;
      cell_ctl = '0;
      merge_ctl = '0;
      case (state_ff)
         brnm_pkg::ST_FILL: begin
            if (pend_valid_ff) begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  cell_ctl.insert = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
               if (pend_last_ff) begin
                  state_in = brnm_pkg::ST_MERGE;
               end
            end
         end
         brnm_pkg::ST_MERGE: begin
            if (count_ff != '0) begin
               merge_ctl.pop = 1'b1;
               cell_ctl.shift = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end else begin
               merge_ctl.flush = 1'b1;
               dropped_in = 1'b0;
               state_in = brnm_pkg::ST_FILL;
            end
         end
         default: begin
            state_in = brnm_pkg::ST_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= brnm_pkg::OFS_BITS'(1);
         state_ff <= brnm_pkg::ST_FILL;
         count_ff <= '0;
         dropped_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            size_ff <= csr_data;
         end
         state_ff <= state_in;
         count_ff <= count_in;
         dropped_ff <= dropped_in;
         pend_valid_ff <= accept;
      end
      if (accept) begin
         pend_ff <= norm_ent;
         pend_last_ff <= req_data.last_range;
      end
   end

   // sorted chain, cell 0 holds the smallest start
   for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
      localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
      brnm_pkg::entry_type left_ent;
      brnm_pkg::entry_type right_ent;
      logic                left_take;

      if (i == 0) begin : g_first
         assign left_ent = pend_ff;
         assign left_take = 1'b0;
      end else begin : g_mid
         assign left_ent = ent_w[i-1];
         assign left_take = take_w[i-1];
      end
      if (i == MAX_RANGES - 1) begin : g_last
         assign right_ent = ent_w[i];
      end else begin : g_inner
         assign right_ent = ent_w[i+1];
      end

      brnm_cell u_cell (
         .clock     (clock),
         .ctl       (cell_ctl),
         .occupied  (IDX < count_ff),
         .new_ent   (pend_ff),
         .left_ent  (left_ent),
         .left_take (left_take),
         .right_ent (right_ent),
         .ent       (ent_w[i]),
         .take      (take_w[i])
      );
   end

   brnm_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .ctl        (merge_ctl),
      .ent        (ent_w[0]),
      .overflow   (dropped_ff),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

### sim/tb_top.sv
// tb_top: self-checking bench for byte_range_normalize_merge
// depends on brnm_pkg and the byte_range_normalize_merge rtl; drives ranges, checks merged output
`timescale 1ns / 1ps

module tb_top;

   localparam int MAX_RANGES = 16;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 start      = 1'b0;
   logic                 busy;
   brnm_pkg::req_type    req_data   = '0;
   logic                 rsp_strobe;
   brnm_pkg::rsp_type    rsp_data;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   brnm_pkg::offset_type csr_data   = '0;

   byte_range_normalize_merge #(
      .MAX_RANGES(MAX_RANGES)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   // predictor state: stream size and the sorted ranges of the open request
   brnm_pkg::offset_type size_reg = 48'd1;
   brnm_pkg::offset_type kept_lo [MAX_RANGES];
   brnm_pkg::offset_type kept_hi [MAX_RANGES];
   int                   kept_cnt = 0;
   bit                   kept_dropped = 1'b0;

   brnm_pkg::req_type range_q [$];
   brnm_pkg::rsp_type merged_q [$];

   int reqs_queued     = 0;
   int reqs_taken      = 0;
   int requests_done   = 0;
   int results_checked = 0;
   int overflow_seen   = 0;
   int mismatches      = 0;
   bit req_fire        = 1'b0;
   int gap_left        = 0;
   int burst_left      = 0;

   task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
      mismatches++;
      $display("%0t ns: mismatch on %s, got %0h, expected %0h", $time, what, got, want);
   endtask

   // clamp one request, slot it into the sorted store, merge on the final one
   task predict_request(input brnm_pkg::req_type r);
      brnm_pkg::offset_type last_byte, lo, hi, span, run_lo, run_hi;
      brnm_pkg::rsp_type    res;
      int                   pos;
      int                   i;
      last_byte = size_reg - 1'b1;
      lo = r.range_start;
      hi = r.range_end;
      if (r.start_absent) begin
         span = r.end_absent ? size_reg : ((hi < size_reg) ? hi : size_reg);
         lo = size_reg - span;
         hi = last_byte;
      end else if (r.end_absent || hi >= size_reg) begin
         hi = last_byte;
      end
      if (kept_cnt >= MAX_RANGES) begin
         kept_dropped = 1'b1;
      end else begin
         pos = kept_cnt;
         // equal starts go behind the ones already stored
         while (pos > 0 && kept_lo[pos-1] > lo) begin
            kept_lo[pos] = kept_lo[pos-1];
            kept_hi[pos] = kept_hi[pos-1];
            pos--;
         end
         kept_lo[pos] = lo;
         kept_hi[pos] = hi;
         kept_cnt++;
      end
      if (r.last_range) begin
         run_lo = kept_lo[0];
         run_hi = kept_hi[0];
         for (i = 1; i <= kept_cnt; i++) begin
            // touch test is one bit wider so the end + 1 cannot wrap
            if (i < kept_cnt && {1'b0, kept_lo[i]} <= {1'b0, run_hi} + 49'd1) begin
               if (kept_hi[i] > run_hi) run_hi = kept_hi[i];
            end else begin
               res.merged_start = run_lo;
               res.merged_end   = run_hi;
               res.last_merged  = (i == kept_cnt);
               res.overflow     = kept_dropped;
               merged_q = {merged_q, res};
               if (i < kept_cnt) begin
                  run_lo = kept_lo[i];
                  run_hi = kept_hi[i];
               end
            end
         end
         kept_cnt = 0;
         kept_dropped = 1'b0;
         requests_done++;
      end
   endtask

   always @(posedge clock) begin
      brnm_pkg::rsp_type want;
      req_fire = start && !busy && !reset;
      if (!reset) begin
         if (csr_valid && csr_ready) size_reg = csr_data;
         if (rsp_strobe) begin
            if (merged_q.size() == 0) begin
               report_mismatch("merged range with none pending", rsp_data.merged_start, 0);
            end else begin
               want = merged_q.pop_front();
               if (rsp_data.merged_start !== want.merged_start)
                  report_mismatch("merged_start", rsp_data.merged_start, want.merged_start);
               if (rsp_data.merged_end !== want.merged_end)
                  report_mismatch("merged_end", rsp_data.merged_end, want.merged_end);
               if (rsp_data.last_merged !== want.last_merged)
                  report_mismatch("last_merged", rsp_data.last_merged, want.last_merged);
               if (rsp_data.overflow !== want.overflow)
                  report_mismatch("overflow", rsp_data.overflow, want.overflow);
               results_checked++;
               if (want.overflow) overflow_seen++;
            end
         end
         if (req_fire) begin
            reqs_taken++;
            predict_request(req_data);
         end
      end
   end

   // mostly short gaps, a few long ones, now and then a burst with none
   function automatic int pick_gap();
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         burst_left = $urandom_range(10, 40);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   always @(negedge clock) begin
      // a request still waiting on busy stays on the port
      if (!(start && !req_fire)) begin
         if (gap_left > 0) begin
            start <= 1'b0;
            gap_left--;
         end else if (range_q.size() != 0) begin
            req_data <= range_q.pop_front();
            start    <= 1'b1;
            gap_left = pick_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   function automatic brnm_pkg::offset_type rand_offset();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[47:0];
   endfunction

   function automatic brnm_pkg::offset_type pick_offset(input brnm_pkg::offset_type sz,
                                                        input brnm_pkg::offset_type near);
      logic [63:0]          w;
      brnm_pkg::offset_type v;
      w = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0:       v = '0;
         1:       v = sz - 1'b1;
         2:       v = sz;
         3:       v = '1;
         4:       v = w[47:0];
         5, 6: begin
            // around the previous end, so ranges touch or overlap
            v = near + brnm_pkg::offset_type'($urandom_range(0, 4));
            v = v - 48'd2;
         end
         default: v = w % sz;
      endcase
      return v;
   endfunction

   function automatic brnm_pkg::req_type dir_range(input brnm_pkg::offset_type s, input bit sa,
                                                   input brnm_pkg::offset_type e, input bit ea,
                                                   input bit last);
      brnm_pkg::req_type r;
      r.range_start  = s;
      r.start_absent = sa;
      r.range_end    = e;
      r.end_absent   = ea;
      r.last_range   = last;
      return r;
   endfunction

   function automatic brnm_pkg::req_type make_range(input brnm_pkg::offset_type sz,
                                                    input brnm_pkg::offset_type near,
                                                    input bit last);
      brnm_pkg::offset_type s, e;
      logic [63:0]          w;
      s = pick_offset(sz, near);
      w = {$urandom, $urandom};
      if ($urandom_range(0, 9) < 6) e = s + brnm_pkg::offset_type'(w % (sz / 4 + 2));
      else e = pick_offset(sz, near);
      return dir_range(s, $urandom_range(0, 6) == 0, e, $urandom_range(0, 6) == 0, last);
   endfunction

   task queue_req(input brnm_pkg::req_type r);
      range_q = {range_q, r};
      reqs_queued++;
   endtask

   task write_size(input brnm_pkg::offset_type v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // every request taken, every merged range seen, block idle and settled
   task drain_phase();
      do @(negedge clock); while (reqs_taken != reqs_queued || merged_q.size() != 0 || busy);
      repeat (20) @(negedge clock);
   endtask

   initial begin
      brnm_pkg::req_type    r;
      brnm_pkg::offset_type sz, near;
      int                   n_items, len, pick, k, ph;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_size(48'd1000);
      @(posedge clock);
      queue_req(dir_range(48'd0, 1'b0, 48'd0, 1'b0, 1'b1));
      queue_req(dir_range('1, 1'b0, '1, 1'b0, 1'b1));        // start past the clamped end
      queue_req(dir_range(48'd0, 1'b1, 48'd100, 1'b0, 1'b1)); // suffix
      queue_req(dir_range('1, 1'b1, '1, 1'b0, 1'b1));        // suffix longer than the stream
      queue_req(dir_range(48'd5, 1'b1, 48'd0, 1'b1, 1'b1));  // whole stream
      queue_req(dir_range(48'd500, 1'b0, 48'd0, 1'b1, 1'b1));
      queue_req(dir_range(48'd10, 1'b0, 48'd1000, 1'b0, 1'b1));
      queue_req(dir_range(48'd0, 1'b1, 48'd0, 1'b0, 1'b1));  // empty suffix
      // touching, overlapping, equal starts, inverted range, one-byte hole
      queue_req(dir_range(48'd100, 1'b0, 48'd199, 1'b0, 1'b0));
      queue_req(dir_range(48'd200, 1'b0, 48'd299, 1'b0, 1'b0));
      queue_req(dir_range(48'd50, 1'b0, 48'd120, 1'b0, 1'b0));
      queue_req(dir_range(48'd400, 1'b0, 48'd410, 1'b0, 1'b0));
      queue_req(dir_range(48'd400, 1'b0, 48'd405, 1'b0, 1'b0));
      queue_req(dir_range(48'd420, 1'b0, 48'd410, 1'b0, 1'b0));
      queue_req(dir_range(48'd412, 1'b0, 48'd430, 1'b0, 1'b0));
      queue_req(dir_range(48'd998, 1'b0, 48'd5, 1'b1, 1'b1));
      drain_phase();

      for (ph = 0; ph < 7; ph++) begin
         case (ph)
            0:       sz = 48'd1;
            1:       sz = '1;
            2:       sz = 48'd64;
            3:       sz = 48'd4096;
            4:       sz = rand_offset() | 48'd1;
            5:       sz = 48'd37;
            default: sz = 48'd2;
         endcase
         write_size(sz);
         @(posedge clock);
         n_items = 0;
         while (n_items < 38) begin
            pick = $urandom_range(0, 99);
            // the first request of setting 2 overfills the store, others now and then
            if (n_items == 0 && ph == 2) len = 18;
            else if (pick < 6) len = $urandom_range(17, 20);
            else if (pick < 20) len = $urandom_range(7, 16);
            else len = $urandom_range(1, 6);
            near = rand_offset() % sz;
            for (k = 0; k < len; k++) begin
               r = make_range(sz, near, k == len - 1);
               near = r.range_end;
               queue_req(r);
            end
            n_items += len;
         end
         drain_phase();
      end

      $display("%0d requests (%0d ranges) over 8 stream sizes, %0d merged ranges checked",
               requests_done, reqs_taken, results_checked);
      $display("%0d merged ranges carried the overflow flag", overflow_seen);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

### byte_range_normalize_merge.f
hdl/brnm_pkg.sv
hdl/brnm_norm.sv
hdl/brnm_cell.sv
hdl/brnm_merge.sv
hdl/byte_range_normalize_merge.sv
sim/tb_top.sv
